@@ src/vbqe_pkg.sv @@
// Shared types and constants for the voxel boundary quad extractor.
package vbqe_pkg;

    // Default build sizes.
    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_MAX_COLS   = 64;
    localparam int DEF_VALUE_BITS = 8;

    // Number of planes along x that the cursor can address.
    localparam int PLANES_MAX = 1024;

    // Entries in the queue between the classifier and the quad emitter.
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2
    } t_reg_idx;

    // Quad orientation codes.
    typedef enum logic [1:0] {
        ORIENT_X = 2'd0,
        ORIENT_Y = 2'd1,
        ORIENT_Z = 2'd2
    } t_orient;

    // One classified voxel: which faces it emits and the running color after each.
    typedef struct packed {
        logic [2:0]      mask;
        logic [2:0][7:0] color;
        logic [9:0]      pos_x;
        logic [5:0]      pos_y;
        logic [5:0]      pos_z;
    } t_quad_entry;

endpackage

@@ src/vbqe_front.sv @@
// Front part: voxel intake, raster cursors, plane memory and face classification.
module vbqe_front #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int VALUE_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [10:0]           i_size_x,
    input  logic [6:0]            i_size_y,
    input  logic [6:0]            i_size_z,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_voxel_value,
    input  logic                  i_queue_full,
    output logic                  o_push,
    output vbqe_pkg::t_quad_entry o_entry
);
    import vbqe_pkg::*;

    localparam int VW    = (VALUE_BITS < 8) ? VALUE_BITS : 8;
    localparam int YW    = $clog2(MAX_ROWS);
    localparam int ZW    = $clog2(MAX_COLS);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [10:0] PlanesLim = 11'(PLANES_MAX);
    localparam logic [10:0] RowsLim   = 11'(MAX_ROWS);
    localparam logic [10:0] ColsLim   = 11'(MAX_COLS);

    // Plane memory: one entry per (y, z).
    logic [VW-1:0] mem [DEPTH];

    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic [9:0]    r_cx;
    logic [YW-1:0] r_cy;
    logic [ZW-1:0] r_cz;
    logic [VW-1:0] r_prev;

    logic          r_s1_valid;
    logic          r_s1_interior;
    logic [VW-1:0] r_s1_v;
    logic [VW-1:0] r_s1_prev;
    logic [VW-1:0] r_nb_x;
    logic [VW-1:0] r_nb_y;
    logic [9:0]    r_s1_px;
    logic [5:0]    r_s1_py;
    logic [5:0]    r_s1_pz;

    logic [10:0]   sx, sy, sz;
    logic [9:0]    cx;
    logic [YW-1:0] cy;
    logic [ZW-1:0] cz;
    logic [9:0]    n_cx;
    logic [YW-1:0] n_cy;
    logic [ZW-1:0] n_cz;
    logic [AW-1:0] idx;
    logic [AW-1:0] idx_up;
    logic [VW-1:0] v;
    logic          accept;
    logic          s1_go;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [VW-1:0] mem_wdata;

    logic [VW-1:0] nbv [3];
    logic [VW-1:0] col [3];
    logic [VW-1:0] c;
    logic [2:0]    hit;

    // Effective sizes: zero counts as one, large values saturate.
    always_comb begin
        sx = (i_size_x == 11'd0) ? 11'd1 : ((i_size_x > PlanesLim) ? PlanesLim : i_size_x);
        sy = (i_size_y == 7'd0) ? 11'd1
           : ((11'(i_size_y) > RowsLim) ? RowsLim : 11'(i_size_y));
        sz = (i_size_z == 7'd0) ? 11'd1
           : ((11'(i_size_z) > ColsLim) ? ColsLim : 11'(i_size_z));
    end

    // Cursors folded back when sizes shrank, and their raster successors.
    always_comb begin
        cx = (11'(r_cx) >= sx) ? '0 : r_cx;
        cy = (11'(r_cy) >= sy) ? '0 : r_cy;
        cz = (11'(r_cz) >= sz) ? '0 : r_cz;
        n_cx = cx;
        n_cy = cy;
        n_cz = cz;
        if (11'(cz) + 11'd1 < sz) begin
            n_cz = cz + ZW'(1);
        end else begin
            n_cz = '0;
            if (11'(cy) + 11'd1 < sy) begin
                n_cy = cy + YW'(1);
            end else begin
                n_cy = '0;
                if (11'(cx) + 11'd1 < sx) begin
                    n_cx = cx + 10'd1;
                end else begin
                    n_cx = '0;
                end
            end
        end
    end

    // Memory addresses of this voxel and of its y-1 neighbor.
    assign idx    = AW'(cy) * AW'(MAX_COLS) + AW'(cz);
    assign idx_up = (cy != '0) ? (idx - AW'(MAX_COLS)) : '0;
    assign v      = i_voxel_value[VW-1:0];

    // Handshake: the classifier stage drains when it has nothing to queue or the queue has room.
    assign s1_go      = !r_s1_valid || (hit == 3'b000) || !i_queue_full;
    assign o_in_ready = !r_clearing && s1_go;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = r_s1_valid && (hit != 3'b000) && !i_queue_full;

    // Write port serves the clearing sweep and then the voxel stream.
    assign mem_we    = r_clearing || accept;
    assign mem_waddr = r_clearing ? r_clr_addr : idx;
    assign mem_wdata = r_clearing ? '0 : v;

    // Plane memory: reads see the contents before this beat's write.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            r_nb_x <= mem[idx];
            r_nb_y <= mem[idx_up];
        end
    end

    // Control state: clearing sweep, cursors, previous voxel, stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_cx       <= '0;
            r_cy       <= '0;
            r_cz       <= '0;
            r_prev     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (accept) begin
                r_cx       <= n_cx;
                r_cy       <= n_cy;
                r_cz       <= n_cz;
                r_prev     <= v;
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Classifier stage payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_interior <= (cx != '0) && (cy != '0) && (cz != '0);
            r_s1_v        <= v;
            r_s1_prev     <= r_prev;
            r_s1_px       <= cx;
            r_s1_py       <= 6'(cy);
            r_s1_pz       <= 6'(cz);
        end
    end

    // Running color against the x, y and z neighbors in turn.
    always_comb begin
        nbv[0] = r_nb_x;
        nbv[1] = r_nb_y;
        nbv[2] = r_s1_prev;
        c      = r_s1_v;
        for (int i = 0; i < 3; i++) begin
            hit[i] = r_s1_interior && (c != nbv[i]);
            if (hit[i]) begin
                if ((c > nbv[i]) && (nbv[i] != '0)) begin
                    c = nbv[i];
                end
                if (c == '0) begin
                    c = nbv[i];
                end
            end
            col[i] = c;
        end
    end

    // Queue entry.
    always_comb begin
        o_entry.mask     = hit;
        o_entry.color[0] = 8'(col[0]);
        o_entry.color[1] = 8'(col[1]);
        o_entry.color[2] = 8'(col[2]);
        o_entry.pos_x    = r_s1_px;
        o_entry.pos_y    = r_s1_py;
        o_entry.pos_z    = r_s1_pz;
    end

endmodule

@@ src/vbqe_queue.sv @@
// Short queue of classified voxels between the front and back parts.
module vbqe_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  vbqe_pkg::t_quad_entry i_entry,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output vbqe_pkg::t_quad_entry o_head
);
    import vbqe_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_quad_entry   r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_entry;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

@@ src/vbqe_back.sv @@
// Back part: expands queued voxels into quads, one per beat, with vertex numbering.
module vbqe_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  vbqe_pkg::t_quad_entry i_head,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_orientation,
    output logic [9:0]            o_pos_x,
    output logic [5:0]            o_pos_y,
    output logic [5:0]            o_pos_z,
    output logic [7:0]            o_quad_color,
    output logic [31:0]           o_vertex_base,
    output logic                  o_last_of_voxel
);
    import vbqe_pkg::*;

    logic [2:0]  r_done;
    logic        r_ovalid;
    logic [31:0] r_vcount;
    t_orient     r_orient;
    logic [9:0]  r_px;
    logic [5:0]  r_py;
    logic [5:0]  r_pz;
    logic [7:0]  r_color;
    logic [31:0] r_vbase;
    logic        r_last;

    logic [2:0]  rem;
    logic [2:0]  pick;
    t_orient     sel;
    logic        last;
    logic        load;

    // Next face of the head entry, lowest orientation first.
    always_comb begin
        rem = i_head.mask & ~r_done;
        if (rem[0]) begin
            sel  = ORIENT_X;
            pick = 3'b001;
        end else if (rem[1]) begin
            sel  = ORIENT_Y;
            pick = 3'b010;
        end else begin
            sel  = ORIENT_Z;
            pick = 3'b100;
        end
        last = ((rem & ~pick) == 3'b000);
    end

    assign load  = !i_empty && (!r_ovalid || i_out_ready);
    assign o_pop = load && last;

    // Progress through the head entry, output valid and vertex counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done   <= '0;
            r_ovalid <= 1'b0;
            r_vcount <= '0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
                r_vcount <= r_vcount + 32'd4;
                r_done   <= last ? 3'b000 : (r_done | pick);
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_orient <= sel;
            r_px     <= i_head.pos_x;
            r_py     <= i_head.pos_y;
            r_pz     <= i_head.pos_z;
            r_color  <= i_head.color[sel];
            r_vbase  <= r_vcount;
            r_last   <= last;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_orientation   = r_orient;
    assign o_pos_x         = r_px;
    assign o_pos_y         = r_py;
    assign o_pos_z         = r_pz;
    assign o_quad_color    = r_color;
    assign o_vertex_base   = r_vbase;
    assign o_last_of_voxel = r_last;

endmodule

@@ src/voxel_boundary_quad_extractor.sv @@
// A voxel's quads pass from the classifier stage register through the queue to the output register.
// Throughput: one voxel per cycle while it yields at most one quad and the queue has room;
// quads leave at one per cycle while i_out_ready is high, up to three per voxel.
// Reset: synchronous, active low; afterward the plane memory's MAX_ROWS*MAX_COLS entries
// (4096 by default) are swept to zero with o_in_ready low. Sizes reset to 64.
module voxel_boundary_quad_extractor #(
    parameter int MAX_ROWS   = vbqe_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = vbqe_pkg::DEF_MAX_COLS,
    parameter int VALUE_BITS = vbqe_pkg::DEF_VALUE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_voxel_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_orientation,
    output logic [9:0]  o_pos_x,
    output logic [5:0]  o_pos_y,
    output logic [5:0]  o_pos_z,
    output logic [7:0]  o_quad_color,
    output logic [31:0] o_vertex_base,
    output logic        o_last_of_voxel
);
    import vbqe_pkg::*;

    logic [10:0] r_size_x;
    logic [6:0]  r_size_y;
    logic [6:0]  r_size_z;
    t_reg_idx    reg_idx;
    logic        cfg_wr;

    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    t_quad_entry q_in;
    t_quad_entry q_head;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Size registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= 11'd64;
            r_size_y <= 7'd64;
            r_size_z <= 7'd64;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SIZE_X: r_size_x <= pwdata[10:0];
                REG_SIZE_Y: r_size_y <= pwdata[6:0];
                REG_SIZE_Z: r_size_z <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        unique case (reg_idx)
            REG_SIZE_X: prdata = 32'(r_size_x);
            REG_SIZE_Y: prdata = 32'(r_size_y);
            REG_SIZE_Z: prdata = 32'(r_size_z);
            default:    prdata = '0;
        endcase
    end

    vbqe_front #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_size_x      (r_size_x),
        .i_size_y      (r_size_y),
        .i_size_z      (r_size_z),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_voxel_value (i_voxel_value),
        .i_queue_full  (q_full),
        .o_push        (push),
        .o_entry       (q_in)
    );

    vbqe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (q_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    vbqe_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_head          (q_head),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_orientation   (o_orientation),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_pos_z         (o_pos_z),
        .o_quad_color    (o_quad_color),
        .o_vertex_base   (o_vertex_base),
        .o_last_of_voxel (o_last_of_voxel)
    );

endmodule

@@ tb/sv/voxel_boundary_quad_extractor_test.sv @@
// Self-checking testbench for the voxel boundary quad extractor.
module voxel_boundary_quad_extractor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import vbqe_pkg::*;

    localparam int PLANE_ROWS    = DEF_MAX_ROWS;
    localparam int PLANE_COLS    = DEF_MAX_COLS;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 20000;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_SPARSE
    } t_ready_style;

    // One quad as the block should deliver it.
    typedef struct packed {
        t_orient     orient;
        logic [9:0]  px;
        logic [5:0]  py;
        logic [5:0]  pz;
        logic [7:0]  hue;
        logic [31:0] base;
        logic        last;
    } t_face_quad;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [3:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_voxel_value  = '0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic [1:0]  o_orientation;
    logic [9:0]  o_pos_x;
    logic [5:0]  o_pos_y;
    logic [5:0]  o_pos_z;
    logic [7:0]  o_quad_color;
    logic [31:0] o_vertex_base;
    logic        o_last_of_voxel;

    // Shadow of the block's configuration and state.
    logic [10:0] cfg_size_x = 11'd64;
    logic [6:0]  cfg_size_y = 7'd64;
    logic [6:0]  cfg_size_z = 7'd64;
    logic [7:0]  mirror_plane [PLANE_ROWS * PLANE_COLS];
    logic [7:0]  mirror_prev = '0;
    int unsigned at_x = 0;
    int unsigned at_y = 0;
    int unsigned at_z = 0;
    // Wraps modulo 2^32 on its own; the wrap lies far beyond any practical run.
    logic [31:0] next_vertex = '0;

    t_face_quad  quads_due [$];
    int          error_count = 0;

    // Sender and receiver pacing.
    int          burst_left  = 0;
    bit          steady_feed = 1'b0;
    logic [7:0]  palette [3];
    t_ready_style ready_style = READY_ALWAYS;
    int          style_left  = 0;
    logic [1:0]  sparse_tick = '0;
    int          quiet_cycles = 0;

    voxel_boundary_quad_extractor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_voxel_value   (i_voxel_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_orientation   (o_orientation),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_pos_z         (o_pos_z),
        .o_quad_color    (o_quad_color),
        .o_vertex_base   (o_vertex_base),
        .o_last_of_voxel (o_last_of_voxel)
    );

    always #5 i_clk = ~i_clk;

    // Prints one line per mismatch and counts every one.
    task automatic note_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic compare_field(input string label, input logic [31:0] got,
                                 input logic [31:0] want_v, input logic [31:0] base);
        if (got !== want_v) begin
            note_error($sformatf("quad with vertex base %0d: %s is %0h, expected %0h",
                                 base, label, got, want_v));
        end
    endtask

    // Size zero counts as one; sizes above the ceiling count as the ceiling.
    function automatic int unsigned usable_size(input int unsigned raw,
                                                input int unsigned ceiling);
        if (raw == 0) begin
            return 1;
        end
        if (raw > ceiling) begin
            return ceiling;
        end
        return raw;
    endfunction

    // Computes the quads that one accepted voxel yields and advances the shadow state.
    function automatic void predict_quads(input logic [7:0] value);
        int unsigned lim_x;
        int unsigned lim_y;
        int unsigned lim_z;
        int unsigned slot;
        int unsigned side;
        int unsigned count;
        logic [7:0]  hue;
        logic [7:0]  near [3];
        t_face_quad  made [3];
        lim_x = usable_size(cfg_size_x, PLANES_MAX);
        lim_y = usable_size(cfg_size_y, PLANE_ROWS);
        lim_z = usable_size(cfg_size_z, PLANE_COLS);
        if (at_x >= lim_x) at_x = 0;
        if (at_y >= lim_y) at_y = 0;
        if (at_z >= lim_z) at_z = 0;
        slot  = at_y * PLANE_COLS + at_z;
        count = 0;

        // Border voxels only update the store.
        if (at_x >= 1 && at_y >= 1 && at_z >= 1) begin
            near[0] = mirror_plane[slot];
            near[1] = mirror_plane[slot - PLANE_COLS];
            near[2] = mirror_prev;
            hue = value;
            for (side = 0; side < 3; side++) begin
                if (hue != near[side]) begin
                    if (hue > near[side] && near[side] != 8'd0) hue = near[side];
                    if (hue == 8'd0) hue = near[side];
                    made[count].orient = t_orient'(side);
                    made[count].px     = at_x[9:0];
                    made[count].py     = at_y[5:0];
                    made[count].pz     = at_z[5:0];
                    made[count].hue    = hue;
                    made[count].base   = next_vertex;
                    made[count].last   = 1'b0;
                    next_vertex += 32'd4;
                    count++;
                end
            end
            for (side = 0; side < count; side++) begin
                made[side].last = (side == count - 1);
                quads_due.push_back(made[side]);
            end
        end

        mirror_plane[slot] = value;
        mirror_prev = value;

        // Raster order: z fastest, then y, then x; the volume wraps at its end.
        if (at_z + 1 < lim_z) begin
            at_z++;
        end else begin
            at_z = 0;
            if (at_y + 1 < lim_y) begin
                at_y++;
            end else begin
                at_y = 0;
                at_x = (at_x + 1 < lim_x) ? at_x + 1 : 0;
            end
        end
    endfunction

    // Writes one size register through a setup phase and an access phase.
    task automatic write_size(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SIZE_X: cfg_size_x = value[10:0];
            REG_SIZE_Y: cfg_size_y = value[6:0];
            REG_SIZE_Z: cfg_size_z = value[6:0];
            default: ;
        endcase
        // Leaves the bus idle before the next transfer starts.
        @(posedge i_clk);
    endtask

    // Presents one voxel and holds it until the block takes the beat.
    task automatic send_voxel(input logic [7:0] value);
        i_in_valid    <= 1'b1;
        i_voxel_value <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_quads(value);
    endtask

    // Sends in bursts of random length with random gaps between them.
    task automatic stream_voxel(input logic [7:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0 || steady_feed) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        send_voxel(value);
    endtask

    // Lowers valid and waits until every predicted quad has come back.
    task automatic hold_until_drained(input bit settle);
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        while (quads_due.size() != 0) @(posedge i_clk);
        if (settle) begin
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end
    endtask

    // Mix of zeros, full-range values and a few repeated colors so equal neighbours occur.
    function automatic logic [7:0] pick_voxel();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1, 2: return 8'($urandom_range(0, 255));
            default: return palette[$urandom_range(0, 2)];
        endcase
    endfunction

    // Receiver: switches among always ready, random stalls and a sparse fixed pattern.
    always @(posedge i_clk) begin
        if (style_left == 0) begin
            ready_style <= t_ready_style'($urandom_range(0, 2));
            style_left  <= $urandom_range(16, 96);
        end else begin
            style_left <= style_left - 1;
        end
        sparse_tick <= sparse_tick + 2'd1;
        case (ready_style)
            READY_ALWAYS: i_out_ready <= 1'b1;
            READY_RANDOM: i_out_ready <= ($urandom_range(0, 2) != 0);
            default:      i_out_ready <= (sparse_tick == 2'b11);
        endcase
    end

    // Checks each output beat against the oldest predicted quad.
    always @(posedge i_clk) begin
        t_face_quad want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (quads_due.size() == 0) begin
                note_error($sformatf("unexpected quad at (%0d,%0d,%0d)",
                                     o_pos_x, o_pos_y, o_pos_z));
            end else begin
                want = quads_due.pop_front();
                compare_field("orientation", 32'(o_orientation), 32'(want.orient), want.base);
                compare_field("pos_x", 32'(o_pos_x), 32'(want.px), want.base);
                compare_field("pos_y", 32'(o_pos_y), 32'(want.py), want.base);
                compare_field("pos_z", 32'(o_pos_z), 32'(want.pz), want.base);
                compare_field("quad_color", 32'(o_quad_color), 32'(want.hue), want.base);
                compare_field("vertex_base", o_vertex_base, want.base, want.base);
                compare_field("last_of_voxel", 32'(o_last_of_voxel), 32'(want.last),
                              want.base);
            end
        end
    end

    // Watchdog: ends the run if no beat moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** voxel_boundary_quad_extractor: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Reset sizes of 64: the first voxels of a volume are border voxels.
    task automatic test_default_sizes();
        stream_voxel(8'd0);
        stream_voxel(8'd255);
        stream_voxel(8'h55);
        stream_voxel(8'hAA);
        hold_until_drained(1'b1);
    endtask

    // A 2x2x2 volume run twice: shrinking sizes mid-volume, the volume wrap,
    // a zero voxel adopting its neighbour, equal and smaller neighbours.
    task automatic test_small_volume();
        logic [7:0] cube [16] = '{8'd9, 8'd0, 8'd4, 8'd200, 8'd7, 8'd3, 8'd255, 8'd0,
                                  8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd4};
        write_size(REG_SIZE_X, 32'd2);
        write_size(REG_SIZE_Y, 32'd2);
        write_size(REG_SIZE_Z, 32'd2);
        foreach (cube[k]) begin
            stream_voxel(cube[k]);
        end
        hold_until_drained(1'b1);
    endtask

    // Zero sizes and sizes beyond their limits.
    task automatic test_size_limits();
        write_size(REG_SIZE_X, 32'd0);
        write_size(REG_SIZE_Y, 32'd127);
        write_size(REG_SIZE_Z, 32'd0);
        stream_voxel(8'd17);
        stream_voxel(8'd0);
        hold_until_drained(1'b1);
        write_size(REG_SIZE_X, 32'd2047);
        write_size(REG_SIZE_Y, 32'd0);
        write_size(REG_SIZE_Z, 32'd127);
        stream_voxel(8'd128);
        stream_voxel(8'd1);
        hold_until_drained(1'b1);
    endtask

    // Small random volumes, resized between phases with the cursors left mid-volume.
    task automatic test_random_volumes();
        int phase;
        int beat;
        int k;
        for (phase = 0; phase < 4; phase++) begin
            hold_until_drained(1'b1);
            write_size(REG_SIZE_X, 32'($urandom_range(1, 4)));
            write_size(REG_SIZE_Y,
                       ($urandom_range(0, 7) == 0) ? 32'd1 : 32'($urandom_range(2, 6)));
            write_size(REG_SIZE_Z,
                       ($urandom_range(0, 7) == 0) ? 32'd1 : 32'($urandom_range(2, 6)));
            for (k = 0; k < 3; k++) begin
                palette[k] = 8'($urandom_range(0, 255));
            end
            steady_feed = (phase == 3);
            for (beat = 0; beat < 18; beat++) begin
                // Once, the sender waits for every pending quad before going on.
                if (phase == 2 && beat == 9) begin
                    hold_until_drained(1'b0);
                end
                stream_voxel(pick_voxel());
            end
        end
        steady_feed = 1'b0;
        hold_until_drained(1'b1);
    endtask

    // Largest sizes entered with the cursors mid-volume; the run crosses the end of a row.
    task automatic test_full_volume();
        int beat;
        int k;
        write_size(REG_SIZE_X, 32'd1024);
        write_size(REG_SIZE_Y, 32'd64);
        write_size(REG_SIZE_Z, 32'd64);
        for (k = 0; k < 3; k++) begin
            palette[k] = 8'($urandom_range(0, 255));
        end
        for (beat = 0; beat < PLANE_COLS + 4; beat++) begin
            stream_voxel(pick_voxel());
        end
        hold_until_drained(1'b1);
    endtask

    initial begin
        foreach (mirror_plane[k]) begin
            mirror_plane[k] = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_sizes();
        test_small_volume();
        test_size_limits();
        test_random_volumes();
        test_full_volume();

        if (error_count == 0) begin
            $display("** voxel_boundary_quad_extractor: PASSED **");
        end else begin
            $display("** voxel_boundary_quad_extractor: FAILED **");
        end
        $finish;
    end

endmodule
